>>> hdl/ihpc_pkg.sv
// Shared types and constants for the IPv4 header parse and checksum unit.
// No dependencies; used by the top level and its port checker.
package ihpc_pkg;

    localparam int unsigned SUM_W    = 21;
    localparam int unsigned PSEUDO_W = 19;
    localparam int unsigned INDEX_W  = 6;

    localparam logic [3:0]         MIN_IHL         = 4'd5;
    localparam logic [INDEX_W-1:0] FIXED_HDR_BYTES = 6'd20;
    localparam logic [15:0]        SUM_ALL_ONES    = 16'hFFFF;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_SUM   = 2'd1,
        STATUS_SHORT_IHL = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]       version_ihl;
        logic [7:0]       tos;
        logic [15:0]      length;
        logic [7:0]       ttl;
        logic [7:0]       proto;
        logic [15:0]      checksum;
        logic [31:0]      source;
        logic [31:0]      destination;
        logic [SUM_W-1:0] sum;
        logic             short_ihl;
    } header_t;

endpackage

>>> hdl/ipv4_header_parse_check_unit.sv
// Top level of the IPv4 header parse and checksum unit.
// Depends on ihpc_pkg for types, status codes and constants.
//
// The unit accepts one header byte per cycle while input ready is high, with
// no gaps required between bytes or headers. Bytes are paired into 16-bit
// words and added into an unfolded 21-bit sum as they arrive, and the fixed
// fields are captured in place. After IHL*4 bytes (or after byte 19 when IHL
// is below five) the completed header moves into a holding stage, from which
// the folded checksum status and the pseudo-header sum are registered at the
// output once the output register is free. Input ready drops only when both
// the holding stage and the output register are full and out_ready is low.
module ipv4_header_parse_check_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  header_byte,
    input  logic        first_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  version,
    output logic [3:0]  header_words,
    output logic [7:0]  service_type,
    output logic [15:0] total_length,
    output logic [7:0]  time_to_live,
    output logic [7:0]  protocol,
    output logic [15:0] header_checksum,
    output logic [31:0] source_address,
    output logic [31:0] destination_address,
    output logic [1:0]  status,
    output logic [18:0] pseudo_sum
);

    logic [ihpc_pkg::INDEX_W-1:0] byte_index_reg, byte_index_next;
    logic                         in_header_reg, in_header_next;
    logic [7:0]                   odd_byte_reg, odd_byte_next;
    ihpc_pkg::header_t            cap_reg, cap_next;

    ihpc_pkg::header_t            mid_reg;
    logic                         mid_valid_reg;
    logic                         out_valid_reg;

    logic                         accept;
    logic                         complete;
    logic                         out_free;
    logic                         mid_free;

    logic [16:0]                  fold1;
    logic [16:0]                  fold2;
    ihpc_pkg::status_t            status_calc;
    logic [ihpc_pkg::PSEUDO_W-1:0] pseudo_calc;

    ihpc_pkg::header_t            res_reg;
    ihpc_pkg::status_t            status_reg;
    logic [ihpc_pkg::PSEUDO_W-1:0] pseudo_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign mid_free = !mid_valid_reg || out_free;
    assign in_ready = mid_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        logic [ihpc_pkg::INDEX_W-1:0] idx;
        logic [ihpc_pkg::INDEX_W-1:0] count;
        logic [3:0]                   ihl;

        byte_index_next = byte_index_reg;
        in_header_next  = in_header_reg;
        odd_byte_next   = odd_byte_reg;
        cap_next        = cap_reg;
        complete        = 1'b0;
        idx             = byte_index_reg;
        count           = '0;
        ihl             = '0;

        if (accept)
        begin
            if (first_byte)
            begin
                cap_next       = '0;
                odd_byte_next  = '0;
                in_header_next = 1'b1;
                idx            = '0;
            end
            if (first_byte || in_header_reg)
            begin
                unique case (idx)
                    6'd0:          cap_next.version_ihl = header_byte;
                    6'd1:          cap_next.tos = header_byte;
                    6'd2, 6'd3:    cap_next.length = {cap_next.length[7:0], header_byte};
                    6'd8:          cap_next.ttl = header_byte;
                    6'd9:          cap_next.proto = header_byte;
                    6'd10, 6'd11:
                        cap_next.checksum = {cap_next.checksum[7:0], header_byte};
                    6'd12, 6'd13, 6'd14, 6'd15:
                        cap_next.source = {cap_next.source[23:0], header_byte};
                    6'd16, 6'd17, 6'd18, 6'd19:
                        cap_next.destination = {cap_next.destination[23:0], header_byte};
                    default: ;
                endcase

                if (!idx[0])
                begin
                    odd_byte_next = header_byte;
                end
                else
                begin
                    cap_next.sum = cap_next.sum
                        + {{(ihpc_pkg::SUM_W-16){1'b0}}, odd_byte_next, header_byte};
                end

                count = idx + 6'd1;
                ihl   = cap_next.version_ihl[3:0];
                cap_next.short_ihl = (ihl < ihpc_pkg::MIN_IHL);
                if (cap_next.short_ihl)
                begin
                    complete = (count == ihpc_pkg::FIXED_HDR_BYTES);
                end
                else
                begin
                    complete = (count == {ihl, 2'b00});
                end
                byte_index_next = count;
                if (complete)
                begin
                    in_header_next = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        fold1 = {1'b0, mid_reg.sum[15:0]}
              + {12'd0, mid_reg.sum[ihpc_pkg::SUM_W-1:16]};
        fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
        if (mid_reg.short_ihl)
        begin
            status_calc = ihpc_pkg::STATUS_SHORT_IHL;
        end
        else if (fold2[15:0] == ihpc_pkg::SUM_ALL_ONES)
        begin
            status_calc = ihpc_pkg::STATUS_OK;
        end
        else
        begin
            status_calc = ihpc_pkg::STATUS_BAD_SUM;
        end
        pseudo_calc = {3'd0, mid_reg.source[31:16]} + {3'd0, mid_reg.source[15:0]}
                    + {3'd0, mid_reg.destination[31:16]}
                    + {3'd0, mid_reg.destination[15:0]}
                    + {11'd0, mid_reg.proto};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            in_header_reg  <= 1'b0;
            mid_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            in_header_reg  <= in_header_next;
            if (mid_free)
            begin
                mid_valid_reg <= complete;
            end
            if (out_free)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        odd_byte_reg <= odd_byte_next;
        cap_reg      <= cap_next;
        if (mid_free && complete)
        begin
            mid_reg <= cap_next;
        end
        if (out_free && mid_valid_reg)
        begin
            res_reg    <= mid_reg;
            status_reg <= status_calc;
            pseudo_reg <= pseudo_calc;
        end
    end

    assign out_valid           = out_valid_reg;
    assign version             = res_reg.version_ihl[7:4];
    assign header_words        = res_reg.version_ihl[3:0];
    assign service_type        = res_reg.tos;
    assign total_length        = res_reg.length;
    assign time_to_live        = res_reg.ttl;
    assign protocol            = res_reg.proto;
    assign header_checksum     = res_reg.checksum;
    assign source_address      = res_reg.source;
    assign destination_address = res_reg.destination;
    assign status              = status_reg;
    assign pseudo_sum          = pseudo_reg;

endmodule

>>> hdl/ihpc_port_checker.sv
// Port-level checker for the IPv4 header parse and checksum unit, with its bind.
// Depends on ihpc_pkg for the status codes and the minimum IHL.
module ihpc_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  header_words,
    input logic [1:0]  status,
    input logic [18:0] pseudo_sum,
    input logic [31:0] source_address
);

    // A result can only appear after an accepted input transaction, with the header passing through the holding stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without a matching input transaction");

    // The short-header status is given exactly when IHL is below five.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == ihpc_pkg::STATUS_SHORT_IHL)
                       == (header_words < ihpc_pkg::MIN_IHL)))
        else $error("status does not agree with IHL");

    // An empty output register never holds back the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output is empty");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(pseudo_sum) && $stable(source_address))
        else $error("stalled result changed");

endmodule

bind ipv4_header_parse_check_unit ihpc_port_checker u_ihpc_port_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .header_words   (header_words),
    .status         (status),
    .pseudo_sum     (pseudo_sum),
    .source_address (source_address)
);
